// ----- rtl/lcdt_pkg.sv -----
// Shared types, constants and the STAT level function for the LCD line timing block.
// No dependencies; imported by lcd_line_timing_and_stat_irq.
package lcdt_pkg;

    // Timing constants
    localparam int DOTS_PER_LINE    = 456;
    localparam int VISIBLE_LINES    = 144;
    localparam int LAST_LINE        = 153;
    localparam int DRAW_START_DOT   = 80;
    localparam int HBLANK_START_DOT = 252;
    localparam int MAX_DOTS_IN      = 255;

    // Dot accumulator must hold (DOTS_PER_LINE - 1) + MAX_DOTS_IN
    localparam int DOT_W  = $clog2(DOTS_PER_LINE + MAX_DOTS_IN);
    localparam int LINE_W = 8;
    localparam int CFG_W  = 8;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_DRAW   = 2'd3
    } mode_t;

    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_RUN  = 1'b1
    } seq_state_t;

    // Configuration register indexes
    typedef enum logic {
        REG_LINE_COMPARE = 1'b0,
        REG_STAT_ENABLE  = 1'b1
    } cfg_index_t;

    // STAT source enable bit positions
    localparam int EN_HBLANK = 0;
    localparam int EN_VBLANK = 1;
    localparam int EN_OAM    = 2;
    localparam int EN_COIN   = 3;

    typedef struct packed {
        logic [7:0] dots_elapsed;
        logic       lcd_on;
    } in_item_t;

    typedef struct packed {
        logic [1:0] current_mode;
        logic [7:0] current_line;
        logic       coincidence;
        logic       vblank_request;
        logic       stat_request;
        logic       render_start;
        logic       sprite_search_start;
    } out_item_t;

    // OR of the enabled STAT sources
    function automatic logic stat_level(mode_t m, logic coin, logic [3:0] en);
        return (m == MODE_HBLANK && en[EN_HBLANK])
            || (m == MODE_VBLANK && en[EN_VBLANK])
            || (m == MODE_OAM    && en[EN_OAM])
            || (coin && en[EN_COIN]);
    endfunction

endpackage

// ----- rtl/lcd_line_timing_and_stat_irq.sv -----
// LCD line timing and STAT/vblank interrupt generator, top level.
// Depends on lcdt_pkg for types, timing constants and the STAT level function.

// One input transfer adds dots_elapsed dot clocks to the line timing and yields
// exactly one result transfer with the mode and line after the step, the
// coincidence flag, and one-shot flags for vblank entry, a STAT rising edge,
// render start and sprite search start.  The block works on one item at a
// time: after an item is loaded the sequencer steps through each timing
// event (mode or line change), then hands the result over when the output
// register is free; each event step reuses a single dot compare/subtract
// unit against the 80, 252 or 456 dot threshold.  A new item is taken as soon
// as the sequencer is idle, even while the previous result still waits in the
// output register.  With lcd_on low the step forces mode 0 (which can fire an
// enabled hblank or coincidence source), clears line, dots and the STAT level,
// and keeps the coincidence flag.  Configuration writes take effect at the
// next mode or line change, or at a display-off step.
module lcd_line_timing_and_stat_irq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lcdt_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lcdt_pkg::out_item_t         out_data,
    input  logic                        cfg_we,
    input  lcdt_pkg::cfg_index_t        cfg_index,
    input  logic [lcdt_pkg::CFG_W-1:0]  cfg_data
);
    import lcdt_pkg::*;

    localparam logic [DOT_W-1:0]  DOTS_LINE_C  = DOT_W'(DOTS_PER_LINE);
    localparam logic [DOT_W-1:0]  DRAW_DOT_C   = DOT_W'(DRAW_START_DOT);
    localparam logic [DOT_W-1:0]  HBLANK_DOT_C = DOT_W'(HBLANK_START_DOT);
    localparam logic [LINE_W-1:0] VIS_LINES_C  = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0] LAST_LINE_C  = LINE_W'(LAST_LINE);

    // Configuration registers
    logic [7:0] line_compare_reg;
    logic [3:0] stat_enable_reg;

    // Timing state
    seq_state_t        state_reg, state_next;
    logic [DOT_W-1:0]  dot_reg, dot_next;
    logic [LINE_W-1:0] line_reg, line_next;
    mode_t             mode_reg, mode_next;
    logic              level_reg, level_next;
    logic              coin_reg, coin_next;

    // Per-item event flags
    logic vbl_reg, vbl_next;
    logic req_reg, req_next;
    logic rend_reg, rend_next;
    logic spr_reg, spr_next;

    // Output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    // Shared dot compare/subtract unit
    logic [DOT_W-1:0] thr;
    logic [DOT_W:0]   diff;
    logic             dot_ge;

    // Scratch for chained STAT evaluations within one event step
    logic [LINE_W-1:0] line_inc;
    mode_t             mode_tmp;
    logic              lev_tmp, lvl_a, lvl_b, coin_tmp;
    logic              in_vblank, out_free;

    assign in_stall  = (state_reg != SEQ_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_vblank = (line_reg >= VIS_LINES_C);
    assign line_inc  = line_reg + LINE_W'(1);

    always_comb
    begin
        if (in_vblank)
            thr = DOTS_LINE_C;
        else
        begin
            case (mode_reg)
                MODE_OAM:  thr = DRAW_DOT_C;
                MODE_DRAW: thr = HBLANK_DOT_C;
                default:   thr = DOTS_LINE_C;
            endcase
        end
        diff   = {1'b0, dot_reg} - {1'b0, thr};
        dot_ge = !diff[DOT_W];
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_compare_reg <= '0;
            stat_enable_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_COMPARE: line_compare_reg <= cfg_data;
                REG_STAT_ENABLE:  stat_enable_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            dot_reg       <= '0;
            line_reg      <= '0;
            mode_reg      <= MODE_OAM;
            level_reg     <= 1'b0;
            coin_reg      <= 1'b0;
            vbl_reg       <= 1'b0;
            req_reg       <= 1'b0;
            rend_reg      <= 1'b0;
            spr_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dot_reg       <= dot_next;
            line_reg      <= line_next;
            mode_reg      <= mode_next;
            level_reg     <= level_next;
            coin_reg      <= coin_next;
            vbl_reg       <= vbl_next;
            req_reg       <= req_next;
            rend_reg      <= rend_next;
            spr_reg       <= spr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        dot_next       = dot_reg;
        line_next      = line_reg;
        mode_next      = mode_reg;
        level_next     = level_reg;
        coin_next      = coin_reg;
        vbl_next       = vbl_reg;
        req_next       = req_reg;
        rend_next      = rend_reg;
        spr_next       = spr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        mode_tmp       = mode_reg;
        lev_tmp        = level_reg;
        coin_tmp       = coin_reg;
        lvl_a          = 1'b0;
        lvl_b          = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = SEQ_RUN;
                    vbl_next   = 1'b0;
                    rend_next  = 1'b0;
                    spr_next   = 1'b0;
                    if (in_data.lcd_on)
                    begin
                        req_next = 1'b0;
                        dot_next = dot_reg + DOT_W'(in_data.dots_elapsed);
                    end
                    else
                    begin
                        // forced hblank still evaluates STAT before clearing
                        lvl_a      = stat_level(MODE_HBLANK, coin_reg, stat_enable_reg);
                        req_next   = lvl_a && !level_reg;
                        mode_next  = MODE_HBLANK;
                        line_next  = '0;
                        dot_next   = '0;
                        level_next = 1'b0;
                    end
                end
            end

            SEQ_RUN:
            begin
                if (in_vblank && mode_reg != MODE_VBLANK)
                begin
                    mode_next  = MODE_VBLANK;
                    vbl_next   = 1'b1;
                    lvl_a      = stat_level(MODE_VBLANK, coin_reg, stat_enable_reg);
                    req_next   = req_reg || (lvl_a && !level_reg);
                    level_next = lvl_a;
                end
                else if (!dot_ge)
                begin
                    // nothing more to do: hand the result over
                    if (out_free)
                    begin
                        out_valid_next               = 1'b1;
                        out_next.current_mode        = mode_reg;
                        out_next.current_line        = line_reg;
                        out_next.coincidence         = coin_reg;
                        out_next.vblank_request      = vbl_reg;
                        out_next.stat_request        = req_reg;
                        out_next.render_start        = rend_reg;
                        out_next.sprite_search_start = spr_reg;
                        state_next                   = SEQ_IDLE;
                    end
                end
                else if (in_vblank)
                begin
                    // end of a vblank line; wrap to line 0 after the last one
                    dot_next  = diff[DOT_W-1:0];
                    line_next = line_inc;
                    req_next  = req_reg;
                    if (line_inc > LAST_LINE_C)
                    begin
                        line_next = '0;
                        mode_tmp  = MODE_OAM;
                        spr_next  = 1'b1;
                        lvl_a     = stat_level(MODE_OAM, coin_reg, stat_enable_reg);
                        req_next  = lvl_a && !level_reg;
                        lev_tmp   = lvl_a;
                    end
                    coin_tmp   = (line_next == line_compare_reg);
                    lvl_b      = stat_level(mode_tmp, coin_tmp, stat_enable_reg);
                    req_next   = req_reg || req_next || (lvl_b && !lev_tmp);
                    mode_next  = mode_tmp;
                    coin_next  = coin_tmp;
                    level_next = lvl_b;
                end
                else if (mode_reg == MODE_OAM)
                begin
                    mode_next  = MODE_DRAW;
                    rend_next  = 1'b1;
                    lvl_a      = stat_level(MODE_DRAW, coin_reg, stat_enable_reg);
                    req_next   = req_reg || (lvl_a && !level_reg);
                    level_next = lvl_a;
                end
                else if (mode_reg == MODE_DRAW)
                begin
                    mode_next  = MODE_HBLANK;
                    lvl_a      = stat_level(MODE_HBLANK, coin_reg, stat_enable_reg);
                    req_next   = req_reg || (lvl_a && !level_reg);
                    level_next = lvl_a;
                end
                else
                begin
                    // end of a visible line (hblank, or stray vblank mode)
                    dot_next  = diff[DOT_W-1:0];
                    line_next = line_inc;
                    coin_tmp  = (line_inc == line_compare_reg);
                    lvl_a     = stat_level(mode_reg, coin_tmp, stat_enable_reg);
                    req_next  = req_reg || (lvl_a && !level_reg);
                    lev_tmp   = lvl_a;
                    if (line_inc < VIS_LINES_C)
                    begin
                        mode_tmp = MODE_OAM;
                        spr_next = 1'b1;
                        lvl_b    = stat_level(MODE_OAM, coin_tmp, stat_enable_reg);
                        req_next = req_next || (lvl_b && !lev_tmp);
                        lev_tmp  = lvl_b;
                    end
                    mode_next  = mode_tmp;
                    coin_next  = coin_tmp;
                    level_next = lev_tmp;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule

// ----- tb/lcd_line_timing_and_stat_irq_test.sv -----
// Self-checking testbench for the LCD line timing and STAT interrupt block.
// Depends on lcdt_pkg for the transfer structs, mode and register enums and timing constants.
`timescale 1ns / 100ps

module lcd_line_timing_and_stat_irq_test;

    import lcdt_pkg::*;

    localparam int ITEMS_PER_PHASE = 330;
    localparam int PHASES          = 6;
    localparam int CYCLE_LIMIT     = 600000;
    // A step walks through at most a few mode or line changes, so this margin
    // after the last result is plenty for the block to settle.
    localparam int SETTLE_CYCLES   = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic       cfg_we = 1'b0;
    cfg_index_t cfg_index = REG_LINE_COMPARE;
    logic [CFG_W-1:0] cfg_data = '0;

    lcd_line_timing_and_stat_irq i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Timing predictor: its own copy of the registers and line state.
    // ------------------------------------------------------------------
    logic [7:0] pred_compare;
    logic [3:0] pred_enable;
    logic [9:0] pred_dots;      // holds up to 455 + 255 before a line wraps
    logic [7:0] pred_line;
    mode_t      pred_mode;
    logic       pred_level;     // OR of enabled STAT sources, last evaluated
    logic       pred_coin;
    logic       pred_stat_edge; // rising edge seen during the current step

    in_item_t  dot_updates [$];       // items waiting to be sent
    out_item_t predicted_status [$];  // results owed by the block, oldest first
    out_item_t oldest_status;

    int error_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int vblank_entries = 0;
    int stat_edges     = 0;
    int lcd_off_steps  = 0;
    int frame_wraps    = 0;
    int cycle_count    = 0;

    // Re-evaluate the STAT line; a low-to-high change is latched for the step.
    task automatic refresh_stat_line();
        logic lvl;
        lvl = (pred_mode == MODE_HBLANK && pred_enable[EN_HBLANK])
            || (pred_mode == MODE_VBLANK && pred_enable[EN_VBLANK])
            || (pred_mode == MODE_OAM    && pred_enable[EN_OAM])
            || (pred_coin && pred_enable[EN_COIN]);
        if (lvl && !pred_level)
            pred_stat_edge = 1'b1;
        pred_level = lvl;
    endtask

    task automatic switch_mode(input mode_t m);
        pred_mode = m;
        refresh_stat_line();
    endtask

    // Coincidence is only looked at when the line moves on.
    task automatic next_line();
        pred_dots = 10'(pred_dots - DOTS_PER_LINE);
        pred_line = pred_line + 8'd1;
    endtask

    task automatic check_coincidence();
        pred_coin = (pred_line == pred_compare);
        refresh_stat_line();
    endtask

    // Advance the line timing by one accepted transfer and queue its result.
    task automatic advance_lcd_timing(input in_item_t item);
        logic      vbl;
        logic      rend;
        logic      spr;
        logic      done;
        out_item_t res;
        vbl = 1'b0;
        rend = 1'b0;
        spr = 1'b0;
        done = 1'b0;
        pred_stat_edge = 1'b0;
        if (!item.lcd_on)
        begin
            // Display off: hblank is forced (and may still fire STAT), then
            // line, dots and the STAT level clear; coincidence is held.
            switch_mode(MODE_HBLANK);
            pred_line = '0;
            pred_dots = '0;
            pred_level = 1'b0;
            lcd_off_steps++;
        end
        else
        begin
            pred_dots = pred_dots + item.dots_elapsed;
            while (!done)
            begin
                if (pred_line >= VISIBLE_LINES)
                begin
                    if (pred_mode != MODE_VBLANK)
                    begin
                        switch_mode(MODE_VBLANK);
                        vbl = 1'b1;
                    end
                    if (pred_dots < DOTS_PER_LINE)
                        done = 1'b1;
                    else
                    begin
                        next_line();
                        if (pred_line > LAST_LINE)
                        begin
                            pred_line = '0;
                            switch_mode(MODE_OAM);
                            spr = 1'b1;
                            frame_wraps++;
                        end
                        check_coincidence();
                    end
                end
                else
                begin
                    case (pred_mode)
                        MODE_OAM:
                        begin
                            if (pred_dots < DRAW_START_DOT)
                                done = 1'b1;
                            else
                            begin
                                switch_mode(MODE_DRAW);
                                rend = 1'b1;
                            end
                        end
                        MODE_DRAW:
                        begin
                            if (pred_dots < HBLANK_START_DOT)
                                done = 1'b1;
                            else
                                switch_mode(MODE_HBLANK);
                        end
                        default:
                        begin
                            // hblank; vblank on a visible line cannot occur
                            if (pred_dots < DOTS_PER_LINE)
                                done = 1'b1;
                            else
                            begin
                                next_line();
                                check_coincidence();
                                if (pred_line < VISIBLE_LINES)
                                begin
                                    switch_mode(MODE_OAM);
                                    spr = 1'b1;
                                end
                            end
                        end
                    endcase
                end
            end
        end
        res.current_mode        = pred_mode;
        res.current_line        = pred_line;
        res.coincidence         = pred_coin;
        res.vblank_request      = vbl;
        res.stat_request        = pred_stat_edge;
        res.render_start        = rend;
        res.sprite_search_start = spr;
        if (vbl)
            vblank_entries++;
        if (pred_stat_edge)
            stat_edges++;
        predicted_status.push_back(res);
    endtask

    task automatic compare_status(input out_item_t want, input out_item_t got);
        if (got.current_mode !== want.current_mode)
        begin
            error_count++;
            $error("current_mode: expected %0d, got %0d", want.current_mode, got.current_mode);
        end
        if (got.current_line !== want.current_line)
        begin
            error_count++;
            $error("current_line: expected %0d, got %0d", want.current_line, got.current_line);
        end
        if (got.coincidence !== want.coincidence)
        begin
            error_count++;
            $error("coincidence: expected %0b, got %0b", want.coincidence, got.coincidence);
        end
        if (got.vblank_request !== want.vblank_request)
        begin
            error_count++;
            $error("vblank_request: expected %0b, got %0b",
                   want.vblank_request, got.vblank_request);
        end
        if (got.stat_request !== want.stat_request)
        begin
            error_count++;
            $error("stat_request: expected %0b, got %0b", want.stat_request, got.stat_request);
        end
        if (got.render_start !== want.render_start)
        begin
            error_count++;
            $error("render_start: expected %0b, got %0b", want.render_start, got.render_start);
        end
        if (got.sprite_search_start !== want.sprite_search_start)
        begin
            error_count++;
            $error("sprite_search_start: expected %0b, got %0b",
                   want.sprite_search_start, got.sprite_search_start);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: bursts of random length, random gaps in between.
    // The prediction is made at the edge where the transfer happens.
    // ------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 1;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_lcd_timing(dot_updates.pop_front());
                items_sent++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    // Now and then a long unbroken run, otherwise short bursts
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                             : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            // A stalled transfer holds its payload; otherwise choose the next one
            if (!(in_valid && in_stall))
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (dot_updates.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= dot_updates[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall pattern.
    // The pattern is redrawn each time stall_age wraps: never, light, heavy or even.
    // ------------------------------------------------------------------
    logic [15:0] stall_pattern = '0;
    logic [5:0]  stall_age = '0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_status.size() == 0)
                begin
                    error_count++;
                    $error("unexpected result transfer: mode %0d line %0d",
                           out_data.current_mode, out_data.current_line);
                end
                else
                begin
                    oldest_status = predicted_status.pop_front();
                    compare_status(oldest_status, out_data);
                    results_seen++;
                end
            end
            stall_age = stall_age + 6'd1;
            if (stall_age == '0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '0;
                    1:       stall_pattern = 16'($urandom) & 16'($urandom);
                    2:       stall_pattern = 16'($urandom) | 16'($urandom);
                    default: stall_pattern = 16'($urandom);
                endcase
            end
            out_stall <= stall_pattern[stall_age[3:0]];
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, predicted_status.size());
            $display("lcd_line_timing_and_stat_irq_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_step(input logic [7:0] dots, input logic on);
        in_item_t item;
        item.dots_elapsed = dots;
        item.lcd_on = on;
        dot_updates.push_back(item);
    endtask

    // Registers only change with nothing in flight
    task automatic wait_idle();
        while (dot_updates.size() != 0 || predicted_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LINE_COMPARE)
            pred_compare = value;
        else
            pred_enable = value[3:0];
    endtask

    // Mostly full-range dot counts so frames actually wrap; some small steps
    // to land on exact mode boundaries, plus both extremes.
    function automatic logic [7:0] pick_dots();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom_range(1, 15));
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [7:0] compare_value;
        logic [3:0] enable_value;
        int         off_odds;

        pred_compare = '0;
        pred_enable = '0;
        pred_dots = '0;
        pred_line = '0;
        pred_mode = MODE_OAM;
        pred_level = 1'b0;
        pred_coin = 1'b0;
        pred_stat_edge = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: walk line 0 to one dot short of each mode boundary and then onto it,
        // then several transitions in one step, display off while hblank and
        // coincidence sources are enabled, and restart in hblank of line 0.
        write_register(REG_LINE_COMPARE, 8'd1);
        write_register(REG_STAT_ENABLE, 8'b0000_1001);
        queue_step(8'd0, 1'b1);
        queue_step(8'd79, 1'b1);
        queue_step(8'd1, 1'b1);      // drawing at dot 80
        queue_step(8'd171, 1'b1);
        queue_step(8'd1, 1'b1);      // hblank at dot 252
        queue_step(8'd203, 1'b1);
        queue_step(8'd1, 1'b1);      // line 1, coincidence
        queue_step(8'd255, 1'b1);
        queue_step(8'd255, 1'b1);
        queue_step(8'd255, 1'b1);
        queue_step(8'd0, 1'b0);      // display off mid-frame
        queue_step(8'd255, 1'b0);    // dots ignored while off
        queue_step(8'd200, 1'b1);    // restart in hblank
        queue_step(8'd255, 1'b1);
        queue_step(8'd1, 1'b1);
        queue_step(8'd0, 1'b1);
        queue_step(8'd255, 1'b1);
        queue_step(8'd170, 1'b1);
        queue_step(8'd128, 1'b1);
        queue_step(8'd0, 1'b0);
        wait_idle();

        // Random phases, each under its own register setting. Extremes of
        // both registers appear; the line compare also sits on the first
        // vblank line, the last line and outside the frame altogether.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            off_odds = 1500;
            case (phase)
                0:
                begin
                    compare_value = 8'd0;
                    enable_value = 4'b1111;
                end
                1:
                begin
                    compare_value = 8'd255;
                    enable_value = 4'b0000;
                end
                2:
                begin
                    compare_value = 8'(LAST_LINE);
                    enable_value = 4'b1010;
                end
                3:
                begin
                    compare_value = 8'(VISIBLE_LINES);
                    enable_value = 4'b0101;
                end
                4:
                begin
                    // noisy phase: the display flips off often
                    compare_value = 8'($urandom_range(0, 20));
                    enable_value = 4'($urandom);
                    off_odds = 15;
                end
                default:
                begin
                    compare_value = 8'($urandom_range(0, LAST_LINE));
                    enable_value = 4'b1000;
                end
            endcase
            write_register(REG_LINE_COMPARE, compare_value);
            write_register(REG_STAT_ENABLE, {4'b0000, enable_value});
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_step(pick_dots(), $urandom_range(0, off_odds - 1) != 0);
            wait_idle();
        end

        $display("%0d steps sent, %0d results checked: %0d frame wraps, %0d vblank entries,",
                 items_sent, results_seen, frame_wraps, vblank_entries);
        $display("%0d STAT edges, %0d display-off steps", stat_edges, lcd_off_steps);
        if (error_count == 0)
            $display("lcd_line_timing_and_stat_irq_test: PASS");
        else
            $display("lcd_line_timing_and_stat_irq_test: FAIL");
        $finish;
    end

endmodule
